@@ hw/rtl/pfm_pkg.sv @@
// Shared types, constants and arithmetic helpers of the power-flow mismatch accumulator.
`default_nettype none

package pfm_pkg;

    localparam int MAX_BUSES      = 4096;
    localparam int FRAC_BITS      = 16;
    localparam int MID_DEPTH_DEF  = 4;
    localparam int OUT_DEPTH_DEF  = 4;
    localparam int SUM_LIMIT_BITS = 40;
    localparam int SLOT_W         = 12;

    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] wide_t;

    localparam wide_t S32_MAX = 64'sd2147483647;
    localparam wide_t S32_MIN = -64'sd2147483648;
    localparam wide_t S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam wide_t S64_MIN = 64'sh8000_0000_0000_0000;
    localparam wide_t SUM_LIM = 64'sd1 <<< SUM_LIMIT_BITS;

    typedef struct packed {
        logic              mode;
        logic              node_class;
        logic [SLOT_W-1:0] out_slot;
        word_t             own_e;
        word_t             own_f;
        word_t             target_p;
        word_t             target_second;
        word_t             conductance;
        word_t             susceptance;
        word_t             other_e;
        word_t             other_f;
        logic              last_term;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] result_slot;
        logic              result_class;
        word_t             p_mismatch;
        word_t             second_mismatch;
    } result_t;

    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_TERM   = 2'd1,
        CMD_LAST   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              node_class;
        word_t             own_e;
        word_t             own_f;
        word_t             target_p;
        word_t             target_second;
    } hdr_t;

    typedef struct packed {
        cmd_kind_t   kind;
        hdr_t        hdr;
        word_t [3:0] op_a;
        word_t [3:0] op_b;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              node_class;
        word_t             target_p;
        word_t             target_second;
        word_t             pv_second;
    } row_t;

    function automatic wide_t mul32(input word_t a, input word_t b);
        return wide_t'(a) * wide_t'(b);
    endfunction

    // Floor division by two to the fraction width.
    function automatic wide_t shr(input wide_t x);
        return x >>> FRAC_BITS;
    endfunction

    function automatic word_t sat32(input wide_t x);
        word_t r;
        if (x > S32_MAX) begin
            r = word_t'(S32_MAX);
        end else if (x < S32_MIN) begin
            r = word_t'(S32_MIN);
        end else begin
            r = word_t'(x);
        end
        return r;
    endfunction

    function automatic wide_t sat_add64(input wide_t a, input wide_t b);
        logic signed [64:0] s;
        wide_t r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r = s[64] ? S64_MIN : S64_MAX;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    function automatic wide_t clamp_sum(input wide_t x);
        wide_t r;
        if (x > SUM_LIM) begin
            r = SUM_LIM;
        end else if (x < -SUM_LIM) begin
            r = -SUM_LIM;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pfm_front.sv @@
// Front end: accepts items, classifies them into commands and queues them for the back end.
`default_nettype none

module pfm_front #(
    parameter int DEPTH = pfm_pkg::MID_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire pfm_pkg::item_t item,
    input  wire logic          cmd_pop,
    output logic               cmd_empty,
    output pfm_pkg::cmd_t      cmd
);
    import pfm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t           queue_mem [DEPTH];
    cmd_t           cmd_in;
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           accept;
    logic           take;

    assign full      = (count_reg == CW'(DEPTH));
    assign cmd_empty = (count_reg == '0);
    assign accept    = push && !full;
    assign take      = cmd_pop && !cmd_empty;
    assign cmd       = queue_mem[rd_ptr_reg];

    // Classify the item and line up the multiplier operands. A header squares
    // its own voltage parts and its second target; a term forms g*ej, b*fj,
    // g*fj and b*ej.
    always_comb
    begin
        cmd_in                  = '0;
        cmd_in.hdr.node_class   = item.node_class;
        cmd_in.hdr.own_e        = item.own_e;
        cmd_in.hdr.own_f        = item.own_f;
        cmd_in.hdr.target_p     = item.target_p;
        cmd_in.hdr.target_second = item.target_second;
        if (32'(item.out_slot) >= MAX_BUSES) begin
            cmd_in.hdr.slot = SLOT_W'(MAX_BUSES - 1);
        end else begin
            cmd_in.hdr.slot = item.out_slot;
        end
        if (item.mode == 1'b0) begin
            cmd_in.kind    = CMD_HEADER;
            cmd_in.op_a[0] = item.own_e;
            cmd_in.op_b[0] = item.own_e;
            cmd_in.op_a[1] = item.own_f;
            cmd_in.op_b[1] = item.own_f;
            cmd_in.op_a[2] = item.target_second;
            cmd_in.op_b[2] = item.target_second;
            cmd_in.op_a[3] = '0;
            cmd_in.op_b[3] = '0;
        end else begin
            cmd_in.kind    = item.last_term ? CMD_LAST : CMD_TERM;
            cmd_in.op_a[0] = item.conductance;
            cmd_in.op_b[0] = item.other_e;
            cmd_in.op_a[1] = item.susceptance;
            cmd_in.op_b[1] = item.other_f;
            cmd_in.op_a[2] = item.conductance;
            cmd_in.op_b[2] = item.other_f;
            cmd_in.op_a[3] = item.susceptance;
            cmd_in.op_b[3] = item.other_e;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (take) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({accept, take})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pfm_back.sv @@
// Back end: pipelined product, accumulate and mismatch datapath for queued commands.
`default_nettype none

module pfm_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pfm_pkg::cmd_t cmd,
    input  wire logic          cmd_empty,
    output logic               cmd_pop,
    input  wire logic          out_full,
    output logic               res_push,
    output pfm_pkg::result_t   res
);
    import pfm_pkg::*;

    logic        adv;

    // Stage 1: captured command.
    logic        v1_reg;
    cmd_t        c1_reg;
    // Stage 2: first products.
    logic        v2_reg;
    cmd_kind_t   k2_reg;
    hdr_t        h2_reg;
    wide_t [3:0] p2_reg;
    // Stage 3: rotated neighbour current, or squared magnitudes for a header.
    logic        v3_reg;
    cmd_kind_t   k3_reg;
    hdr_t        h3_reg;
    word_t       rr3_reg;
    word_t       ri3_reg;
    wide_t       u2_3_reg;
    wide_t       v2_3_reg;
    // Row registers, written when a header reaches stage 4.
    word_t       row_e_reg;
    word_t       row_f_reg;
    row_t        row_reg;
    // Stage 4: second products.
    logic        v4_reg;
    cmd_kind_t   k4_reg;
    row_t        r4_reg;
    wide_t [3:0] m4_reg;
    // Stage 5: power increments.
    logic        v5_reg;
    cmd_kind_t   k5_reg;
    row_t        r5_reg;
    wide_t       dp5_reg;
    wide_t       dq5_reg;
    // Accumulators and final sums of a finished row.
    wide_t       sum_p_reg;
    wide_t       sum_q_reg;
    wide_t       acc_p_next;
    wide_t       acc_q_next;
    logic        v6_reg;
    row_t        r6_reg;
    wide_t       fin_p_reg;
    wide_t       fin_q_reg;

    // The whole pipeline holds while the result queue is full.
    assign adv        = !out_full;
    assign cmd_pop    = adv && !cmd_empty;
    assign res_push   = adv && v6_reg;
    assign acc_p_next = sat_add64(sum_p_reg, dp5_reg);
    assign acc_q_next = sat_add64(sum_q_reg, dq5_reg);

    always_comb
    begin
        res.result_slot  = r6_reg.slot;
        res.result_class = r6_reg.node_class;
        res.p_mismatch   = sat32(wide_t'(r6_reg.target_p) - clamp_sum(fin_p_reg));
        if (r6_reg.node_class) begin
            res.second_mismatch = r6_reg.pv_second;
        end else begin
            res.second_mismatch = sat32(wide_t'(r6_reg.target_second) - clamp_sum(fin_q_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            c1_reg <= cmd;

            k2_reg <= c1_reg.kind;
            h2_reg <= c1_reg.hdr;
            for (int i = 0; i < 4; i++) begin
                p2_reg[i] <= mul32(c1_reg.op_a[i], c1_reg.op_b[i]);
            end

            k3_reg   <= k2_reg;
            h3_reg   <= h2_reg;
            rr3_reg  <= sat32(shr(p2_reg[0]) - shr(p2_reg[1]));
            ri3_reg  <= sat32(shr(p2_reg[2]) + shr(p2_reg[3]));
            u2_3_reg <= shr(p2_reg[2]);
            v2_3_reg <= shr(p2_reg[0]) + shr(p2_reg[1]);

            k4_reg    <= k3_reg;
            r4_reg    <= row_reg;
            m4_reg[0] <= mul32(row_e_reg, rr3_reg);
            m4_reg[1] <= mul32(row_f_reg, ri3_reg);
            m4_reg[2] <= mul32(row_f_reg, rr3_reg);
            m4_reg[3] <= mul32(row_e_reg, ri3_reg);

            k5_reg  <= k4_reg;
            r5_reg  <= r4_reg;
            dp5_reg <= shr(m4_reg[0]) + shr(m4_reg[1]);
            dq5_reg <= shr(m4_reg[2]) - shr(m4_reg[3]);

            r6_reg    <= r5_reg;
            fin_p_reg <= acc_p_next;
            fin_q_reg <= acc_q_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            row_e_reg <= '0;
            row_f_reg <= '0;
            row_reg   <= '0;
            sum_p_reg <= '0;
            sum_q_reg <= '0;
        end else if (adv) begin
            v1_reg <= !cmd_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg && (k5_reg == CMD_LAST);
            if (v3_reg && (k3_reg == CMD_HEADER)) begin
                row_e_reg             <= h3_reg.own_e;
                row_f_reg             <= h3_reg.own_f;
                row_reg.slot          <= h3_reg.slot;
                row_reg.node_class    <= h3_reg.node_class;
                row_reg.target_p      <= h3_reg.target_p;
                row_reg.target_second <= h3_reg.target_second;
                row_reg.pv_second     <= sat32(u2_3_reg - v2_3_reg);
            end
            if (v5_reg) begin
                unique case (k5_reg)
                    CMD_TERM:
                    begin
                        sum_p_reg <= acc_p_next;
                        sum_q_reg <= acc_q_next;
                    end
                    default:
                    begin
                        sum_p_reg <= '0;
                        sum_q_reg <= '0;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pfm_result_queue.sv @@
// Result queue: holds finished mismatch results until the receiver pops them.
`default_nettype none

module pfm_result_queue #(
    parameter int DEPTH = pfm_pkg::OUT_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_push,
    input  wire pfm_pkg::result_t res,
    output logic                  out_full,
    input  wire logic             pop,
    output logic                  empty,
    output pfm_pkg::result_t      result
);
    import pfm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t       queue_mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          put;
    logic          take;

    assign out_full = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign put      = res_push && !out_full;
    assign take     = pop && !empty;
    assign result   = queue_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (put) begin
            queue_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (put) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (take) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({put, take})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/power_flow_mismatch_accumulator.sv @@
// Top level of the Newton-Raphson power-flow mismatch accumulator.
//
// Usage: the block is fed one bus row at a time. A header transaction (mode 0)
// loads the bus voltage, its class, its targets and its output slot and clears
// the running sums. Each term transaction (mode 1) carries one admittance
// nonzero and the neighbour voltage; the one marked last_term produces a
// single result transaction with the P mismatch and either the Q mismatch
// (PQ bus) or the squared voltage mismatch (PV bus). All values are Q16.16.
// Input side: an item is taken on a clock edge with push high and full low.
// Output side: the oldest result sits on the result port while empty is low
// and leaves on a clock edge with pop high.
// Timing: one item per cycle is sustained while the result queue is not full;
// the 64-bit accumulator add is the only per-cycle loop. A last term reaches
// the result port through six pipeline stages, the first loaded from the
// command queue, and then the result queue write.
// If the receiver stalls until the result queue is full, the datapath freezes
// in place, the command queue fills, and full then holds off the sender.
// Reset (rst_n low) empties both queues, drops work in flight and clears the
// row registers and the sums to zero.

`default_nettype none

module power_flow_mismatch_accumulator #(
    parameter int MID_DEPTH = pfm_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = pfm_pkg::OUT_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire pfm_pkg::item_t   item,
    output logic                  empty,
    input  wire logic             pop,
    output pfm_pkg::result_t      result
);
    import pfm_pkg::*;

    cmd_t    cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    out_full;
    logic    res_push;
    result_t res;

    // Front end: classification and the command queue that decouples the
    // sender from the arithmetic pipeline.
    pfm_front #(
        .DEPTH (MID_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd       (cmd)
    );

    // Back end: products, accumulation and the final mismatch arithmetic.
    pfm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .res_push  (res_push),
        .res       (res)
    );

    // Result queue: lets the back end run ahead of a slow receiver.
    pfm_result_queue #(
        .DEPTH (OUT_DEPTH)
    ) u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .out_full (out_full),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

    // The back end must never write a result into a full result queue.
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !out_full)
        else $error("result written while the result queue is full");

    // While the result queue is full the pipeline is frozen and takes no command.
    assert property (@(posedge clk) disable iff (!rst_n) out_full |-> !cmd_pop)
        else $error("command taken while the pipeline is frozen");

    // An accepted transaction is waiting in the command queue on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (push && !full) |=> !cmd_empty)
        else $error("accepted transaction missing from the command queue");

endmodule

`default_nettype wire
